### hw/rtl/rmf_pkg.sv
// Shared types and constants for the running median filter.
// No dependencies; imported by rmf_merge_step and running_median_filter_u16.
`default_nettype none

package rmf_pkg;

    localparam int unsigned SAMPLE_W = 16;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Item kind carried on s_tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Decision of one merge step over the sorted list
    typedef struct packed {
        logic consume;   // advance past the element under the read head
        logic wr_en;     // write one entry to the new list
        logic wr_new;    // the written entry is the incoming sample
        logic clr_rem;   // the evicted sample has been skipped
        logic set_ins;   // the incoming sample has been placed
        logic done;      // the new list is complete
    } step_t;

endpackage

`default_nettype wire

### hw/rtl/running_median_filter_u16.sv
// Running median filter top level: sequencer, sample ring and sorted-list memory.
// Depends on rmf_pkg and rmf_merge_step.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata = sample[15:0], s_tuser = kind
//  m_*       out  m_tvalid/m_tready   m_tdata = median[15:0]
//  cfg_*     in   cfg_we              cfg_data = stop_value[15:0]
//
// Each sample runs a merge pass (PREP, RUN, FINISH) over the sorted list of the
// samples held before it (at most WINDOW): the pass reads the list one entry per
// cycle, but holds the head for the step that places the new sample, through a
// single memory read port. A clear skips the pass and goes straight to FINISH.
// The next item is not taken until the result is posted.
// Reset empties the window at once; no clearing pass is needed.
// The result register lets a new item in while the last result is unread;
// the block stalls at its final step until the result register is free.
`default_nettype none

module running_median_filter_u16 #(
    parameter int unsigned WINDOW = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire rmf_pkg::sample_t s_tdata,   // [15:0] sample
    input  wire logic             s_tuser,   // [0] kind
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output rmf_pkg::sample_t      m_tdata,   // [15:0] median
    input  wire logic             cfg_we,
    input  wire rmf_pkg::sample_t cfg_data
);
    import rmf_pkg::*;

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FULL     = CW'(WINDOW);
    localparam logic [AW-1:0] LAST_POS = AW'(WINDOW - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]    state_reg, state_next;
    sample_t       stop_reg;
    sample_t       new_reg;
    sample_t       evict_reg;
    sample_t       median_reg;
    logic          clr_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] count_reg;   // list length after this item
    logic [CW-1:0] mpos_reg;    // list position of the median
    logic [CW-1:0] idx_reg;     // read head in the old list
    logic [CW-1:0] widx_reg;    // write position in the new list
    logic          rem_reg;
    logic          ins_reg;
    logic [AW-1:0] oldest_reg;
    logic          bank_reg;
    logic          out_valid_reg;
    sample_t       out_data_reg;

    // arrival-order ring and double-banked sorted list
    sample_t ring_mem [0:WINDOW-1];
    sample_t sort_mem [0:(1 << (AW + 1))-1];
    sample_t ring_rd_reg;
    sample_t sort_rd_reg;

    step_t         step;
    logic [CW-1:0] rd_idx;
    logic [CW-1:0] count_calc;
    sample_t       wr_data;
    sample_t       adj_sample;
    logic          s_fire;
    logic          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign adj_sample = (s_tdata == stop_reg) ? s_tdata + 1'b1 : s_tdata;
    assign count_calc = (fill_reg == FULL) ? fill_reg : fill_reg + 1'b1;

    rmf_merge_step u_step (
        .elem         (sort_rd_reg),
        .new_sample   (new_reg),
        .evict_sample (evict_reg),
        .in_range     (idx_reg < fill_reg),
        .rem_pending  (rem_reg),
        .ins_done     (ins_reg),
        .step         (step)
    );

    assign wr_data = step.wr_new ? new_reg : sort_rd_reg;

    always_comb
    begin
        rd_idx = idx_reg;
        if (state_reg == ST_PREP)
        begin
            rd_idx = '0;
        end
        else if ((state_reg == ST_RUN) && step.consume)
        begin
            rd_idx = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = (s_tuser == KIND_CLEAR) ? ST_FINISH : ST_PREP;
                end
            end
            ST_PREP:   state_next = ST_RUN;
            ST_RUN:
            begin
                if (step.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ring_rd_reg <= ring_mem[oldest_reg];
        if (state_reg == ST_PREP)
        begin
            ring_mem[oldest_reg] <= new_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sort_rd_reg <= sort_mem[{bank_reg, rd_idx[AW-1:0]}];
        if ((state_reg == ST_RUN) && step.wr_en)
        begin
            sort_mem[{~bank_reg, widx_reg[AW-1:0]}] <= wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            new_reg <= adj_sample;
        end
        if (state_reg == ST_PREP)
        begin
            evict_reg <= ring_rd_reg;
            count_reg <= count_calc;
            mpos_reg  <= (count_calc - 1'b1) >> 1;
        end
        if ((state_reg == ST_RUN) && step.wr_en && (widx_reg == mpos_reg))
        begin
            median_reg <= wr_data;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_data_reg <= clr_reg ? '0 : median_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stop_reg      <= '0;
            clr_reg       <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            widx_reg      <= '0;
            rem_reg       <= 1'b0;
            ins_reg       <= 1'b0;
            oldest_reg    <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                stop_reg <= cfg_data;
            end
            // post a new result, or drop the one just taken
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        clr_reg <= (s_tuser == KIND_CLEAR);
                    end
                end
                ST_PREP:
                begin
                    idx_reg  <= '0;
                    widx_reg <= '0;
                    rem_reg  <= (fill_reg == FULL);
                    ins_reg  <= 1'b0;
                end
                ST_RUN:
                begin
                    idx_reg <= rd_idx;
                    if (step.wr_en)
                    begin
                        widx_reg <= widx_reg + 1'b1;
                    end
                    if (step.clr_rem)
                    begin
                        rem_reg <= 1'b0;
                    end
                    if (step.set_ins)
                    begin
                        ins_reg <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (clr_reg)
                        begin
                            fill_reg   <= '0;
                            oldest_reg <= '0;
                        end
                        else
                        begin
                            // commit the new list and advance the ring
                            fill_reg   <= count_reg;
                            bank_reg   <= ~bank_reg;
                            oldest_reg <= (oldest_reg == LAST_POS) ? '0 : oldest_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // the evicted sample must have been found in the sorted list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step.done) |-> !rem_reg)
        else $error("evicted sample not found in sorted list");

    // writes never run ahead of reads by more than the one inserted entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (widx_reg <= idx_reg + 1'b1))
        else $error("merge write index ahead of read index");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL)
        else $error("fill count beyond window");

    // one item at a time: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous item busy");

endmodule

`default_nettype wire

### hw/rtl/rmf_merge_step.sv
// Compare unit: one step of merging the sorted list with one eviction
// and one insertion. Depends on rmf_pkg.
`default_nettype none

module rmf_merge_step (
    input  wire rmf_pkg::sample_t elem,         // element under the read head
    input  wire rmf_pkg::sample_t new_sample,   // sample being inserted
    input  wire rmf_pkg::sample_t evict_sample, // sample leaving the window
    input  wire logic             in_range,     // read head still inside the old list
    input  wire logic             rem_pending,  // eviction not yet done
    input  wire logic             ins_done,     // insertion already done
    output rmf_pkg::step_t        step
);
    import rmf_pkg::*;

    always_comb
    begin
        step = '0;
        if (in_range)
        begin
            if (rem_pending && (elem == evict_sample))
            begin
                // drop the evicted sample from the list
                step.consume = 1'b1;
                step.clr_rem = 1'b1;
            end
            else if (!ins_done && (new_sample > elem))
            begin
                // place the new sample ahead of the first smaller element, hold the head
                step.wr_en   = 1'b1;
                step.wr_new  = 1'b1;
                step.set_ins = 1'b1;
            end
            else
            begin
                step.wr_en   = 1'b1;
                step.consume = 1'b1;
            end
        end
        else
        begin
            step.done = 1'b1;
            if (!ins_done)
            begin
                step.wr_en   = 1'b1;
                step.wr_new  = 1'b1;
                step.set_ins = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### test/running_median_filter_u16_test.sv
// Self-checking testbench for running_median_filter_u16: a directed table and then
// random sample streams, checked against table medians or a window-median predictor in this file.
// Depends on rmf_pkg and the running_median_filter_u16 RTL.
`default_nettype none

module running_median_filter_u16_test;

    import rmf_pkg::*;

    localparam int WINDOW       = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = WINDOW + 8;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CLEAR,
        OP_STOP_WRITE
    } row_op_t;

    typedef struct packed {
        row_op_t op;
        sample_t value;
        logic    has_median;
        sample_t median;
    } row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    s_tvalid;
    logic    s_tready;
    sample_t s_tdata;
    logic    s_tuser;
    logic    m_tvalid;
    logic    m_tready;
    sample_t m_tdata;
    logic    cfg_we;
    sample_t cfg_data;

    // Predictor state: held samples in arrival order and the stop value
    sample_t held_samples[$];
    sample_t stop_value = '0;
    sample_t median_q[$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;

    // Stop value 65535 first, then a nonzero stop value with zero samples
    row_t directed_rows[26] = '{
        '{OP_STOP_WRITE, 16'hFFFF, 1'b0, 16'h0000},
        '{OP_CLEAR,      16'h0000, 1'b1, 16'h0000},
        '{OP_SAMPLE,     16'hFFFF, 1'b1, 16'h0000},
        '{OP_SAMPLE,     16'h0000, 1'b1, 16'h0000},
        '{OP_SAMPLE,     16'hFFFE, 1'b1, 16'h0000},
        '{OP_SAMPLE,     16'hFFFE, 1'b1, 16'hFFFE},
        '{OP_CLEAR,      16'hFFFF, 1'b1, 16'h0000},
        '{OP_SAMPLE,     16'h1234, 1'b1, 16'h1234},
        '{OP_STOP_WRITE, 16'h00FF, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h00FF, 1'b1, 16'h1234},
        '{OP_SAMPLE,     16'h0000, 1'b1, 16'h0100},
        '{OP_SAMPLE,     16'hAAAA, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h5555, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'hFFFF, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h0001, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h8000, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h7FFF, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h0000, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'hFFFE, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h0F0F, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'hF0F0, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h3C3C, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h00FF, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'hC3C3, 1'b0, 16'h0000},
        '{OP_SAMPLE,     16'h0002, 1'b0, 16'h0000},
        '{OP_CLEAR,      16'h5A5A, 1'b1, 16'h0000}
    };

    running_median_filter_u16 #(
        .WINDOW (WINDOW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Advance the window by one item and return the upper median of what is held
    function automatic sample_t predict_median(logic kind, sample_t raw);
        sample_t adjusted;
        sample_t ranked[$];
        if (kind == KIND_CLEAR)
        begin
            held_samples.delete();
            return '0;
        end
        adjusted = raw;
        if (raw == stop_value)
            adjusted = raw + 16'd1;
        held_samples.push_back(adjusted);
        if (held_samples.size() > WINDOW)
            held_samples.delete(0);
        ranked = held_samples;
        ranked.rsort();
        return ranked[(ranked.size() + 1) / 2 - 1];
    endfunction

    // Favor stop-value hits, duplicates of held values and extremes
    function automatic sample_t pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return stop_value;
        if (sel < 35 && held_samples.size() > 0)
            return held_samples[$urandom_range(held_samples.size() - 1)];
        if (sel < 45)
        begin
            case ($urandom_range(3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h0001;
                default: return 16'hFFFE;
            endcase
        end
        if (sel < 65)
            return sample_t'($urandom_range(15));
        return sample_t'($urandom_range(16'hFFFF));
    endfunction

    task automatic send_item(logic kind, sample_t value, logic has_median, sample_t median);
        int      gap;
        sample_t predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_median(kind, value);
        median_q.push_back(has_median ? median : predicted);
    endtask

    // Drop valid, wait for every pending median, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_stop(sample_t value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        stop_value = value;
    endtask

    task automatic run_phase(int count, sample_t stop, int send_pct, int recv_pct, int hold);
        drain();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_cycles    = hold;
        write_stop(stop);
        repeat (count)
        begin
            if ($urandom_range(99) < 5)
                send_item(KIND_CLEAR, sample_t'($urandom_range(16'hFFFF)), 1'b0, '0);
            else
                send_item(KIND_SAMPLE, pick_sample(), 1'b0, '0);
        end
    endtask

    // Sink side: random stalls, or a long hold-off while hold_cycles runs down
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (median_q.size() == 0)
            begin
                $error("median: unexpected transaction, actual %0d", m_tdata);
                fail_count++;
            end
            else if (m_tdata !== median_q[0])
            begin
                $error("median: expected %0d, actual %0d", median_q[0], m_tdata);
                fail_count++;
                median_q.delete(0);
            end
            else
            begin
                median_q.delete(0);
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    initial
    begin
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("running_median_filter_u16_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_SAMPLE;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == OP_STOP_WRITE)
            begin
                drain();
                write_stop(directed_rows[i].value);
            end
            else
            begin
                send_item((directed_rows[i].op == OP_CLEAR) ? KIND_CLEAR : KIND_SAMPLE,
                          directed_rows[i].value, directed_rows[i].has_median,
                          directed_rows[i].median);
            end
        end

        // Hold the sink off long enough that the block backs up into the source
        run_phase(100, 16'h0000, 0, 0, 300);
        run_phase(100, 16'hFFFF, 64, 0, 0);
        run_phase(100, sample_t'($urandom_range(16'hFFFF)), 0, 64, 0);
        run_phase(100, sample_t'($urandom_range(15)), 14, 14, 0);
        drain();

        if (fail_count == 0)
            $display("running_median_filter_u16_test: PASS");
        else
            $display("running_median_filter_u16_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_merge_step.sv
hw/rtl/running_median_filter_u16.sv
test/running_median_filter_u16_test.sv
